@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define CHK_IMPL(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("check failed");
`define CHK_NEXT(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("check failed");
`endif

@@ rtl/core/lcs_pkg.sv @@
// Types and constants of the longest common subsequence block.
// No dependencies.
`default_nettype none
package lcs_pkg;
	localparam logic [1:0] FUNC_APPEND_A = 2'd0;
	localparam logic [1:0] FUNC_APPEND_B = 2'd1;
	localparam logic [1:0] FUNC_COMPUTE  = 2'd2;

	typedef struct packed {
		logic [1:0] func;
		logic [7:0] symbol;
	} lcs_in_t;

	typedef struct packed {
		logic       valid_res;
		logic [7:0] out_symbol;
		logic [5:0] lcs_length;
		logic       overflow;
		logic       last;
	} lcs_out_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_FILL, ST_TRACE, ST_WAIT, ST_EMIT, ST_DONE
	} lcs_state_t;

	typedef struct packed {
		logic load;
		logic fill_start;
		logic fill_step;
		logic trace_start;
		logic trace_step;
		logic emit_start;
		logic emit_step;
		logic clear;
	} lcs_cmd_t;

	typedef struct packed {
		logic fill_done;
		logic trace_done;
		logic emit_last;
	} lcs_sts_t;
endpackage
`default_nettype wire

@@ rtl/core/lcs_with_traceback.sv @@
// Longest common subsequence: one load transaction per cycle while idle; a
// compute fills the score memory cell by cell, then traces back through the
// score memory, then emits the result symbols one by one.
// Reset clears lengths, overflow flag and controller; stores need no clear.
// Depends on lcs_pkg, lcs_ctrl, lcs_datapath.
`default_nettype none
module lcs_with_traceback import lcs_pkg::*; #(
	parameter int MAX_LEN = 32
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	output logic         in_ready,
	input  wire lcs_in_t in_data,
	output logic         out_valid,
	input  wire logic    out_ready,
	output lcs_out_t     out_data
);
	lcs_cmd_t cmd;
	lcs_sts_t sts;

	lcs_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_data, .in_ready,
		.out_valid, .out_ready, .sts, .cmd
	);

	lcs_datapath #(.MAX_LEN(MAX_LEN)) u_dp (
		.clk, .arst_n, .cmd, .in_data, .sts, .res(out_data)
	);
endmodule
`default_nettype wire

@@ rtl/core/lcs_datapath.sv @@
// Datapath: string stores, score memory, traceback and output buffer.
// Depends on lcs_pkg.
`default_nettype none
module lcs_datapath import lcs_pkg::*; #(
	parameter int MAX_LEN = 32
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire lcs_cmd_t cmd,
	input  wire lcs_in_t  in_data,
	output lcs_sts_t      sts,
	output lcs_out_t      res
);
	localparam int LW = $clog2(MAX_LEN + 1);
	localparam int IW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam int SIDE = MAX_LEN + 1;
	localparam int DEPTH = SIDE * SIDE;
	localparam int AW = $clog2(DEPTH);

	logic [7:0] a_mem [MAX_LEN];
	logic [7:0] b_mem [MAX_LEN];
	logic [7:0] rev_mem [MAX_LEN];
	logic [LW-1:0] score_mem [DEPTH];
	logic [LW-1:0] alen_q, blen_q, i_q, j_q, len_q, k_q;
	logic drop_q;
	logic [LW-1:0] up_q, rd_q;
	logic [1:0] tph_q;
	logic [7:0] sym_q;

	logic [LW-1:0] fi_q, fj_q;
	logic fph_q;
	logic [LW-1:0] fdiag_q, fleft_q;
	logic [LW-1:0] v_cell, diag, upv, lftv, m1;
	logic [LW-1:0] t_up, t_left;
	logic eq_f, eq_t;
	logic [AW-1:0] wr_addr, rd_addr;

	function automatic logic [AW-1:0] addr(input logic [LW-1:0] r, input logic [LW-1:0] c);
		logic [AW+LW:0] t;
		t = (AW+LW+1)'(r) * (AW+LW+1)'(SIDE) + (AW+LW+1)'(c);
		return t[AW-1:0];
	endfunction

	assign eq_f = a_mem[IW'(fi_q - 1'b1)] == b_mem[IW'(fj_q - 1'b1)];
	assign upv  = (fi_q == LW'(1)) ? '0 : rd_q;
	assign diag = fdiag_q;
	assign lftv = fleft_q;
	assign m1   = (upv > lftv) ? upv : lftv;
	assign v_cell = eq_f ? diag + 1'b1 : ((m1 > diag) ? m1 : diag);
	assign wr_addr = addr(fi_q, fj_q);
	assign eq_t = a_mem[IW'(i_q - 1'b1)] == b_mem[IW'(j_q - 1'b1)];
	assign t_up = (i_q == LW'(1)) ? '0 : rd_q;
	assign t_left = (j_q == LW'(1)) ? '0 : rd_q;

	always_comb begin
		if (cmd.fill_step) rd_addr = addr(fi_q - 1'b1, fj_q);
		else if (tph_q == 2'd1) rd_addr = addr(i_q - 1'b1, j_q);
		else rd_addr = addr(i_q, j_q - 1'b1);
	end

	always_ff @(posedge clk) begin
		if (cmd.load && in_data.func == FUNC_APPEND_A && alen_q < LW'(MAX_LEN))
			a_mem[IW'(alen_q)] <= in_data.symbol;
		if (cmd.load && in_data.func == FUNC_APPEND_B && blen_q < LW'(MAX_LEN))
			b_mem[IW'(blen_q)] <= in_data.symbol;
		if (cmd.fill_step && fph_q)
			score_mem[wr_addr] <= v_cell;
		rd_q <= score_mem[rd_addr];
		if (cmd.trace_step && i_q != '0 && j_q != '0 && tph_q == 2'd0 && eq_t)
			rev_mem[IW'(len_q)] <= a_mem[IW'(i_q - 1'b1)];
		if (cmd.trace_step && tph_q == 2'd2)
			up_q <= t_up;
		sym_q <= rev_mem[IW'(len_q - k_q - 1'b1)];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alen_q <= '0;
			blen_q <= '0;
			drop_q <= 1'b0;
			fi_q <= '0;
			fj_q <= '0;
			fph_q <= 1'b0;
			fdiag_q <= '0;
			fleft_q <= '0;
			i_q <= '0;
			j_q <= '0;
			len_q <= '0;
			k_q <= '0;
			tph_q <= '0;
		end else begin
			if (cmd.load) begin
				if (in_data.func == FUNC_APPEND_A) begin
					if (alen_q < LW'(MAX_LEN)) alen_q <= alen_q + 1'b1;
					else drop_q <= 1'b1;
				end else if (in_data.func == FUNC_APPEND_B) begin
					if (blen_q < LW'(MAX_LEN)) blen_q <= blen_q + 1'b1;
					else drop_q <= 1'b1;
				end
			end
			if (cmd.fill_start) begin
				fi_q <= LW'(1);
				fj_q <= LW'(1);
				fph_q <= 1'b0;
				fdiag_q <= '0;
				fleft_q <= '0;
			end else if (cmd.fill_step) begin
				if (!fph_q) begin
					fph_q <= 1'b1;
				end else begin
					fph_q <= 1'b0;
					if (fj_q == blen_q) begin
						fj_q <= LW'(1);
						fi_q <= fi_q + 1'b1;
						fdiag_q <= '0;
						fleft_q <= '0;
					end else begin
						fj_q <= fj_q + 1'b1;
						fdiag_q <= upv;
						fleft_q <= v_cell;
					end
				end
			end
			if (cmd.trace_start) begin
				i_q <= alen_q;
				j_q <= blen_q;
				len_q <= '0;
				tph_q <= '0;
			end else if (cmd.trace_step && i_q != '0 && j_q != '0) begin
				if (tph_q == 2'd0) begin
					if (eq_t) begin
						len_q <= len_q + 1'b1;
						i_q <= i_q - 1'b1;
						j_q <= j_q - 1'b1;
					end else begin
						tph_q <= 2'd1;
					end
				end else if (tph_q == 2'd1) begin
					tph_q <= 2'd2;
				end else if (tph_q == 2'd2) begin
					tph_q <= 2'd3;
				end else begin
					tph_q <= 2'd0;
					if (up_q > t_left) i_q <= i_q - 1'b1;
					else j_q <= j_q - 1'b1;
				end
			end
			if (cmd.emit_start) k_q <= '0;
			else if (cmd.emit_step) k_q <= k_q + 1'b1;
			if (cmd.clear) begin
				alen_q <= '0;
				blen_q <= '0;
				drop_q <= 1'b0;
			end
		end
	end

	always_comb begin
		sts.fill_done = (alen_q == '0) || (blen_q == '0) || (fi_q > alen_q);
		sts.trace_done = (i_q == '0) || (j_q == '0);
		sts.emit_last = (len_q == '0) || (k_q + 1'b1 == len_q);
		res.valid_res = len_q != '0;
		res.out_symbol = (len_q != '0) ? sym_q : 8'd0;
		res.lcs_length = 6'(len_q);
		res.overflow = drop_q;
		res.last = sts.emit_last;
	end
endmodule
`default_nettype wire

@@ rtl/core/lcs_ctrl.sv @@
// Controller state machine for load, fill, traceback and emit.
// Depends on lcs_pkg.
`default_nettype none
module lcs_ctrl import lcs_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	input  wire lcs_in_t  in_data,
	output logic          in_ready,
	output logic          out_valid,
	input  wire logic     out_ready,
	input  wire lcs_sts_t sts,
	output lcs_cmd_t      cmd
);
	lcs_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					if (in_data.func == FUNC_COMPUTE) begin
						cmd.fill_start = 1'b1;
						state_d = ST_FILL;
					end
				end
			end
			ST_FILL: begin
				if (sts.fill_done) begin
					cmd.trace_start = 1'b1;
					state_d = ST_TRACE;
				end else begin
					cmd.fill_step = 1'b1;
				end
			end
			ST_TRACE: begin
				if (sts.trace_done) begin
					cmd.emit_start = 1'b1;
					state_d = ST_WAIT;
				end else begin
					cmd.trace_step = 1'b1;
				end
			end
			ST_WAIT: state_d = ST_EMIT;
			ST_EMIT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					if (sts.emit_last) begin
						cmd.clear = 1'b1;
						state_d = ST_DONE;
					end else begin
						cmd.emit_step = 1'b1;
						state_d = ST_WAIT;
					end
				end
			end
			ST_DONE: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end
endmodule
`default_nettype wire

@@ rtl/core/lcs_checker.sv @@
// Port checker for lcs_with_traceback, bound to the top level.
// Depends on lcs_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module lcs_checker import lcs_pkg::*; (
	input wire logic     clk,
	input wire logic     arst_n,
	input wire logic     in_ready,
	input wire logic     out_valid,
	input wire logic     out_ready,
	input wire lcs_out_t out_data
);
	`CHK_IMPL(a_no_overlap, clk, arst_n, out_valid, !in_ready)
	`CHK_IMPL(a_empty_last, clk, arst_n, out_valid && !out_data.valid_res, out_data.last)
	`CHK_NEXT(a_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_data))
endmodule
bind lcs_with_traceback lcs_checker u_chk (.*);
`default_nettype wire

@@ tb/sv/tb_top.sv @@
// Testbench of the longest common subsequence block with traceback.
// Drives string loads and computes, predicts each subsequence and checks every result.
// Depends on lcs_pkg and lcs_with_traceback.
`default_nettype none
module tb_top;
	import lcs_pkg::*;

	localparam int MAX_LEN = 32;
	localparam int WATCHDOG_LIMIT = 200000;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	lcs_in_t in_data;
	logic out_valid;
	logic out_ready;
	lcs_out_t out_data;

	lcs_with_traceback #(.MAX_LEN(MAX_LEN)) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	lcs_in_t pending_items[$];
	lcs_out_t expected_symbols[$];

	logic [7:0] str_a[MAX_LEN];
	logic [7:0] str_b[MAX_LEN];
	int len_a;
	int len_b;
	logic dropped;

	int send_idle_pct;
	int recv_idle_pct;
	int hold_off_cycles;
	int mismatch_count;
	int idle_cycles;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic add_item(input lcs_in_t it);
		pending_items = {pending_items, it};
	endtask

	task automatic add_expect(input lcs_out_t r);
		expected_symbols = {expected_symbols, r};
	endtask

	task automatic predict_item(input lcs_in_t item);
		int score[MAX_LEN+1][MAX_LEN+1];
		logic [7:0] rev[MAX_LEN];
		int i;
		int j;
		int n;
		lcs_out_t r;
		case (item.func)
			FUNC_APPEND_A: begin
				if (len_a < MAX_LEN) begin
					str_a[len_a] = item.symbol;
					len_a++;
				end else
					dropped = 1'b1;
			end
			FUNC_APPEND_B: begin
				if (len_b < MAX_LEN) begin
					str_b[len_b] = item.symbol;
					len_b++;
				end else
					dropped = 1'b1;
			end
			FUNC_COMPUTE: begin
				for (i = 0; i <= len_a; i++)
					for (j = 0; j <= len_b; j++)
						score[i][j] = 0;
				for (i = 1; i <= len_a; i++)
					for (j = 1; j <= len_b; j++)
						if (str_a[i-1] == str_b[j-1])
							score[i][j] = score[i-1][j-1] + 1;
						else if (score[i-1][j] > score[i][j-1])
							score[i][j] = score[i-1][j];
						else
							score[i][j] = score[i][j-1];
				n = 0;
				i = len_a;
				j = len_b;
				while (i > 0 && j > 0) begin
					if (str_a[i-1] == str_b[j-1]) begin
						rev[n] = str_a[i-1];
						n++;
						i--;
						j--;
					end else if (score[i-1][j] > score[i][j-1])
						i--;
					else
						j--;
				end
				if (n == 0) begin
					r = '0;
					r.overflow = dropped;
					r.last = 1'b1;
					add_expect(r);
				end else begin
					for (i = 0; i < n; i++) begin
						r.valid_res = 1'b1;
						r.out_symbol = rev[n-1-i];
						r.lcs_length = 6'(n);
						r.overflow = dropped;
						r.last = (i == n - 1);
						add_expect(r);
					end
				end
				len_a = 0;
				len_b = 0;
				dropped = 1'b0;
			end
			default: ;
		endcase
	endtask

	function automatic lcs_in_t make_item(input logic [1:0] f, input logic [7:0] s);
		lcs_in_t it;
		it.func = f;
		it.symbol = s;
		return it;
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
		end else begin
			if (in_valid && in_ready)
				predict_item(in_data);
			if (!in_valid || in_ready) begin
				if (pending_items.size() > 0 &&
				    $urandom_range(99, 0) >= send_idle_pct) begin
					in_valid <= 1'b1;
					in_data <= pending_items.pop_front();
				end else
					in_valid <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_symbols.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("unexpected result %p", out_data);
				end else begin
					lcs_out_t e;
					e = expected_symbols.pop_front();
					if (e.valid_res !== out_data.valid_res ||
					    e.out_symbol !== out_data.out_symbol ||
					    e.lcs_length !== out_data.lcs_length ||
					    e.overflow !== out_data.overflow ||
					    e.last !== out_data.last) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display("mismatch: expected %p actual %p", e, out_data);
					end
				end
			end
			if (hold_off_cycles > 0) begin
				hold_off_cycles--;
				out_ready <= 1'b0;
			end else
				out_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("tb_top failed");
				$finish;
			end
		end
	end

	task automatic push_load(input int na, input int nb, input int alpha);
		for (int k = 0; k < na; k++)
			add_item(make_item(FUNC_APPEND_A, 8'($urandom_range(alpha, 0))));
		for (int k = 0; k < nb; k++)
			add_item(make_item(FUNC_APPEND_B, 8'($urandom_range(alpha, 0))));
	endtask

	task automatic push_random(input int count);
		int r;
		int alpha;
		for (int k = 0; k < count; k++) begin
			r = $urandom_range(99, 0);
			alpha = ($urandom_range(3, 0) == 0) ? 255 : $urandom_range(5, 1);
			if (r < 70) begin
				push_load($urandom_range(($urandom_range(9, 0) == 0) ? 36 : 8, 0),
					$urandom_range(($urandom_range(9, 0) == 0) ? 36 : 8, 0), alpha);
				add_item(make_item(FUNC_COMPUTE, 8'($urandom)));
			end else if (r < 80)
				add_item(make_item(FUNC_COMPUTE, 8'($urandom)));
			else if (r < 85)
				add_item(make_item(2'd3, 8'($urandom)));
			else
				add_item(make_item(2'($urandom_range(1, 0)), 8'($urandom)));
		end
	endtask

	task automatic wait_drain();
		while (pending_items.size() > 0 || in_valid || expected_symbols.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		len_a = 0;
		len_b = 0;
		dropped = 1'b0;
		mismatch_count = 0;
		idle_cycles = 0;
		hold_off_cycles = 0;
		send_idle_pct = 15;
		recv_idle_pct = 49;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// empty strings, one empty string
		add_item(make_item(FUNC_COMPUTE, 8'hff));
		add_item(make_item(FUNC_APPEND_A, 8'h00));
		add_item(make_item(FUNC_COMPUTE, 8'h00));
		add_item(make_item(2'd3, 8'hAA));
		// extremes of symbol, full match
		add_item(make_item(FUNC_APPEND_A, 8'hff));
		add_item(make_item(FUNC_APPEND_A, 8'h00));
		add_item(make_item(FUNC_APPEND_B, 8'hff));
		add_item(make_item(FUNC_APPEND_B, 8'h00));
		add_item(make_item(FUNC_COMPUTE, 8'h55));
		// no common symbol
		add_item(make_item(FUNC_APPEND_A, 8'h01));
		add_item(make_item(FUNC_APPEND_B, 8'h02));
		add_item(make_item(FUNC_COMPUTE, 8'h00));
		// tie in traceback
		add_item(make_item(FUNC_APPEND_A, 8'h0a));
		add_item(make_item(FUNC_APPEND_A, 8'h0b));
		add_item(make_item(FUNC_APPEND_B, 8'h0b));
		add_item(make_item(FUNC_APPEND_B, 8'h0a));
		add_item(make_item(FUNC_COMPUTE, 8'h00));
		// both strings full plus overflow, identical content
		for (int k = 0; k < MAX_LEN + 1; k++) begin
			add_item(make_item(FUNC_APPEND_A, 8'(k * 7)));
			add_item(make_item(FUNC_APPEND_B, 8'(k * 7)));
		end
		add_item(make_item(FUNC_COMPUTE, 8'h00));
		wait_drain();

		// pause: receiver holds off while the sender queues more items
		push_random(4);
		hold_off_cycles = 3000;
		push_random(12);
		wait_drain();

		send_idle_pct = 49;
		recv_idle_pct = 15;
		push_random(11);
		wait_drain();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		push_random(11);
		wait_drain();

		if (mismatch_count == 0 && expected_symbols.size() == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end
endmodule
`default_nettype wire
